FILE: hdl/bcpc_pkg.sv
`default_nettype none
package bcpc_pkg;

    localparam int ACC_W = 65;

    // Filter weights, Q16.16 of 0.3 and 0.7.
    localparam logic signed [31:0] FILT_NEW = 32'sd19661;
    localparam logic signed [31:0] FILT_OLD = 32'sd45875;

    localparam logic signed [18:0] INTEGRAL_LIMIT = 19'sd10000;
    localparam logic signed [31:0] LIFT_THRESHOLD = 32'sd5000;
    localparam logic [4:0]         COUNT_LIMIT    = 5'd20;
    localparam logic signed [26:0] LEVEL_BAND_A   = 27'sd327680;
    localparam logic signed [27:0] LEVEL_BAND_R   = 28'sd327680;

    // Configuration register indexes.
    localparam logic [2:0] REG_ANGLE_KP       = 3'd0;
    localparam logic [2:0] REG_ANGLE_KD       = 3'd1;
    localparam logic [2:0] REG_SPEED_KP       = 3'd2;
    localparam logic [2:0] REG_SPEED_KI       = 3'd3;
    localparam logic [2:0] REG_YAW_KD         = 3'd4;
    localparam logic [2:0] REG_MID_ANGLE      = 3'd5;
    localparam logic [2:0] REG_SPEED_SETPOINT = 3'd6;
    localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd7;

    // Command to the shared multiply-accumulate unit.
    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
    } t_mac_cmd;

    // Division by 2^16 that truncates toward zero.
    function automatic logic signed [ACC_W-1:0] div_q16(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] biased;
        biased = x + (x[ACC_W-1] ? 65'sd65535 : 65'sd0);
        return biased >>> 16;
    endfunction

    // Division by 2^32 that truncates toward zero.
    function automatic logic signed [ACC_W-1:0] div_q32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] biased;
        biased = x + (x[ACC_W-1] ? 65'sd4294967295 : 65'sd0);
        return biased >>> 32;
    endfunction

    // Saturation to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if (x > 65'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -65'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/bcpc_mac.sv
`default_nettype none
module bcpc_mac
    import bcpc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_mac_cmd                i_cmd,
    input  wire logic signed [31:0]      i_a,
    input  wire logic signed [31:0]      i_b,
    output logic signed [ACC_W-1:0]      o_acc
);

    // The product is registered before it reaches the accumulator.
    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] prod_ext;

    assign prod_ext = {r_prod[63], r_prod};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_cmd.acc_load) begin
            r_acc <= prod_ext;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + prod_ext;
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

FILE: hdl/bcpc_lift.sv
`default_nettype none
module bcpc_lift
    import bcpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic signed [31:0] i_last_angle,
    input  wire logic signed [24:0] i_roll_q,
    input  wire logic signed [27:0] i_rrate_q,
    input  wire logic signed [24:0] i_mid_angle,
    output logic                    o_on_ground
);

    logic       r_on_ground, n_on_ground;
    logic [4:0] r_lift_count, n_lift_count;
    logic [4:0] r_settle_count, n_settle_count;
    logic       tilted;
    logic       level;
    logic signed [26:0] roll_ext;
    logic signed [26:0] mid_ext;

    assign roll_ext = {{2{i_roll_q[24]}}, i_roll_q};
    assign mid_ext  = {{2{i_mid_angle[24]}}, i_mid_angle};

    assign tilted = (i_last_angle > LIFT_THRESHOLD) || (i_last_angle < -LIFT_THRESHOLD);
    assign level  = (roll_ext < mid_ext + LEVEL_BAND_A) && (roll_ext > mid_ext - LEVEL_BAND_A)
                 && (i_rrate_q < LEVEL_BAND_R) && (i_rrate_q > -LEVEL_BAND_R);

    always_comb begin
        n_on_ground    = r_on_ground;
        n_lift_count   = r_lift_count;
        n_settle_count = r_settle_count;
        if (r_on_ground) begin
            n_lift_count = tilted ? r_lift_count + 5'd1 : 5'd0;
            if (n_lift_count > COUNT_LIMIT) begin
                n_on_ground  = 1'b0;
                n_lift_count = 5'd0;
            end
        end
        // Evaluated also in the frame that just lifted off.
        if (!n_on_ground) begin
            if (level) begin
                n_settle_count = r_settle_count + 5'd1;
            end
            if (n_settle_count > COUNT_LIMIT) begin
                n_settle_count = 5'd0;
                n_on_ground    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_ground    <= 1'b1;
            r_lift_count   <= 5'd0;
            r_settle_count <= 5'd0;
        end else if (i_step) begin
            r_on_ground    <= n_on_ground;
            r_lift_count   <= n_lift_count;
            r_settle_count <= n_settle_count;
        end
    end

    assign o_on_ground = r_on_ground;

endmodule
`default_nettype wire

FILE: hdl/balance_cascade_pid_controller_unit.sv
`default_nettype none
// Cascade balance controller for a two-wheeled robot. Each input beat is one
// sensor frame (two encoder counts, roll, roll rate and yaw rate); each frame
// produces exactly one output beat with the left and right motor drives and
// a drive-enabled flag. A speed PI loop (low-passed error, clamped integral)
// sets the target of an angle PD loop, a yaw-rate damping term is subtracted
// from the left drive and added to the right one, and both drives are clamped
// to the programmed limit. Lift-off detection watches the previous frame's
// angle output and forces the drives to zero, clearing the PI state, until the
// robot has been near level for enough frames. All arithmetic is Q16.16 fixed
// point with truncation toward zero. The result is loaded into the output
// register at the end of the sequence, and the input is ready again in the
// cycle after that, when the sequencer has returned to idle. The work
// is sequenced through a single shared 32x32 multiplier with a 65-bit
// accumulator, and the input is not ready while a frame is in progress. The
// output sits in a register of its own, so a frame can be taken while the
// previous result still waits; if the result is not taken by the time the
// next one is ready, the sequencer holds.
// Configuration registers are written through a plain write port and should
// only change while the block is idle.
module balance_cascade_pid_controller_unit
    import bcpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write port.
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    // Sensor frame input.
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_left_count,
    input  wire logic signed [15:0] i_right_count,
    input  wire logic signed [15:0] i_roll_raw,
    input  wire logic signed [15:0] i_roll_rate_raw,
    input  wire logic signed [15:0] i_yaw_rate_raw,
    // Motor drive output.
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [16:0]      o_left_drive,
    output logic signed [16:0]      o_right_drive,
    output logic                    o_drive_enabled
);

    // Sequencer states, in the order they run.
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_LIFT = 5'd1;
    localparam logic [4:0] ST_M1   = 5'd2;
    localparam logic [4:0] ST_M2   = 5'd3;
    localparam logic [4:0] ST_A2   = 5'd4;
    localparam logic [4:0] ST_FE   = 5'd5;
    localparam logic [4:0] ST_INT  = 5'd6;
    localparam logic [4:0] ST_M3   = 5'd7;
    localparam logic [4:0] ST_M4   = 5'd8;
    localparam logic [4:0] ST_A4   = 5'd9;
    localparam logic [4:0] ST_VEL  = 5'd10;
    localparam logic [4:0] ST_DIFF = 5'd11;
    localparam logic [4:0] ST_M5   = 5'd12;
    localparam logic [4:0] ST_M6   = 5'd13;
    localparam logic [4:0] ST_A6   = 5'd14;
    localparam logic [4:0] ST_VERT = 5'd15;
    localparam logic [4:0] ST_L7   = 5'd16;
    localparam logic [4:0] ST_TURN = 5'd17;
    localparam logic [4:0] ST_DRV  = 5'd18;

    // Configuration registers.
    logic signed [31:0] r_angle_kp;
    logic signed [31:0] r_angle_kd;
    logic signed [31:0] r_speed_kp;
    logic signed [31:0] r_speed_ki;
    logic signed [31:0] r_yaw_kd;
    logic signed [24:0] r_mid_angle;
    logic signed [16:0] r_speed_setpoint;
    logic [15:0]        r_drive_limit;

    // Sequencer and frame registers.
    logic [4:0]         r_state;
    logic signed [15:0] r_left_count;
    logic signed [15:0] r_right_count;
    logic signed [24:0] r_roll_q;
    logic signed [27:0] r_rrate_q;
    logic signed [27:0] r_yrate_q;
    logic signed [18:0] r_err;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_diff;
    logic signed [26:0] r_turn;

    // Controller state carried between frames.
    logic signed [17:0] r_filt_err;
    logic signed [14:0] r_integral;
    logic signed [31:0] r_last_angle;

    // Output register.
    logic               r_out_valid;
    logic signed [16:0] r_left_drive;
    logic signed [16:0] r_right_drive;
    logic               r_drive_enabled;

    // Shared unit connections.
    t_mac_cmd                mac_cmd;
    logic signed [31:0]      mac_a;
    logic signed [31:0]      mac_b;
    logic signed [ACC_W-1:0] mac_acc;

    logic on_ground;
    logic accept;
    logic out_load;

    // Scaled sensor values, computed at the input beat.
    logic signed [24:0] roll_q_in;
    logic signed [27:0] rrate_q_in;
    logic signed [27:0] yrate_q_in;
    logic signed [24:0] roll_ext;
    logic signed [27:0] rrate_ext;
    logic signed [27:0] yrate_ext;

    // Step-local arithmetic.
    logic signed [18:0]      err_next;
    logic signed [18:0]      int_sum;
    logic signed [14:0]      int_next;
    logic signed [ACC_W-1:0] acc_q16;
    logic signed [ACC_W-1:0] acc_q32;
    logic signed [49:0]      diff_wide;
    logic signed [32:0]      m1_wide;
    logic signed [32:0]      m2_wide;
    logic signed [32:0]      lim_pos;
    logic signed [32:0]      lim_neg;
    logic signed [16:0]      m1_clamped;
    logic signed [16:0]      m2_clamped;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == ST_IDLE);
    assign out_load = (r_state == ST_DRV) && (!r_out_valid || i_ready);

    // roll * 360 and rate * 4000 as shift-add constant products.
    assign roll_ext  = {{9{i_roll_raw[15]}}, i_roll_raw};
    assign rrate_ext = {{12{i_roll_rate_raw[15]}}, i_roll_rate_raw};
    assign yrate_ext = {{12{i_yaw_rate_raw[15]}}, i_yaw_rate_raw};
    assign roll_q_in  = (roll_ext <<< 8) + (roll_ext <<< 6) + (roll_ext <<< 5)
                      + (roll_ext <<< 3);
    assign rrate_q_in = (rrate_ext <<< 12) - (rrate_ext <<< 6) - (rrate_ext <<< 5);
    assign yrate_q_in = (yrate_ext <<< 12) - (yrate_ext <<< 6) - (yrate_ext <<< 5);

    // Speed error: negated left count plus right count minus the setpoint.
    assign err_next = {{3{r_right_count[15]}}, r_right_count}
                    - {{3{r_left_count[15]}}, r_left_count}
                    - {{2{r_speed_setpoint[16]}}, r_speed_setpoint};

    assign acc_q16 = div_q16(mac_acc);
    assign acc_q32 = div_q32(mac_acc);

    // Integral update with clamp to +-10000.
    assign int_sum = {{4{r_integral[14]}}, r_integral} + {r_filt_err[17], r_filt_err};
    always_comb begin
        if (int_sum > INTEGRAL_LIMIT) begin
            int_next = INTEGRAL_LIMIT[14:0];
        end else if (int_sum < -INTEGRAL_LIMIT) begin
            int_next = 15'(-INTEGRAL_LIMIT);
        end else begin
            int_next = int_sum[14:0];
        end
    end

    // Angle error: roll minus (speed output in degrees plus balance angle).
    assign diff_wide = {{25{r_roll_q[24]}}, r_roll_q}
                     - {{2{r_vel[31]}}, r_vel, 16'b0}
                     - {{25{r_mid_angle[24]}}, r_mid_angle};

    // Drive mixing and clamping.
    assign m1_wide = {r_last_angle[31], r_last_angle} - {{6{r_turn[26]}}, r_turn};
    assign m2_wide = {r_last_angle[31], r_last_angle} + {{6{r_turn[26]}}, r_turn};
    assign lim_pos = {17'b0, r_drive_limit};
    assign lim_neg = -lim_pos;

    always_comb begin
        if (m1_wide > lim_pos) begin
            m1_clamped = lim_pos[16:0];
        end else if (m1_wide < lim_neg) begin
            m1_clamped = lim_neg[16:0];
        end else begin
            m1_clamped = m1_wide[16:0];
        end
        if (m2_wide > lim_pos) begin
            m2_clamped = lim_pos[16:0];
        end else if (m2_wide < lim_neg) begin
            m2_clamped = lim_neg[16:0];
        end else begin
            m2_clamped = m2_wide[16:0];
        end
    end

    // Multiplier operand selection and accumulator control for each step.
    always_comb begin
        mac_cmd = '0;
        mac_a   = '0;
        mac_b   = '0;
        unique case (r_state) inside
            ST_M1: begin
                mac_cmd.mul_en = 1'b1;
                mac_a = FILT_NEW;
                mac_b = {{13{r_err[18]}}, r_err};
            end
            ST_M2: begin
                mac_cmd.mul_en   = 1'b1;
                mac_cmd.acc_load = 1'b1;
                mac_a = FILT_OLD;
                mac_b = {{14{r_filt_err[17]}}, r_filt_err};
            end
            ST_M3: begin
                mac_cmd.mul_en = 1'b1;
                mac_a = r_speed_kp;
                mac_b = {{14{r_filt_err[17]}}, r_filt_err};
            end
            ST_M4: begin
                mac_cmd.mul_en   = 1'b1;
                mac_cmd.acc_load = 1'b1;
                mac_a = r_speed_ki;
                mac_b = {{17{r_integral[14]}}, r_integral};
            end
            ST_M5: begin
                mac_cmd.mul_en = 1'b1;
                mac_a = r_angle_kp;
                mac_b = r_diff;
            end
            ST_M6: begin
                mac_cmd.mul_en   = 1'b1;
                mac_cmd.acc_load = 1'b1;
                mac_a = r_angle_kd;
                mac_b = {{4{r_rrate_q[27]}}, r_rrate_q};
            end
            ST_VERT: begin
                // The yaw product starts while the angle sum is read out.
                mac_cmd.mul_en = 1'b1;
                mac_a = r_yaw_kd;
                mac_b = {{4{r_yrate_q[27]}}, r_yrate_q};
            end
            ST_A2, ST_A4, ST_A6: begin
                mac_cmd.acc_add = 1'b1;
            end
            ST_L7: begin
                mac_cmd.acc_load = 1'b1;
            end
            default: begin
                mac_cmd = '0;
            end
        endcase
    end

    bcpc_mac u_mac (
        .i_clk (i_clk),
        .i_cmd (mac_cmd),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (mac_acc)
    );

    bcpc_lift u_lift (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (r_state == ST_LIFT),
        .i_last_angle (r_last_angle),
        .i_roll_q     (r_roll_q),
        .i_rrate_q    (r_rrate_q),
        .i_mid_angle  (r_mid_angle),
        .o_on_ground  (on_ground)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_kp       <= 32'sd13107200;
            r_angle_kd       <= 32'sd786432;
            r_speed_kp       <= 32'sd26214;
            r_speed_ki       <= 32'sd141;
            r_yaw_kd         <= 32'sd786432;
            r_mid_angle      <= 25'sd26214;
            r_speed_setpoint <= 17'sd0;
            r_drive_limit    <= 16'd7200;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ANGLE_KP:       r_angle_kp       <= i_cfg_data;
                REG_ANGLE_KD:       r_angle_kd       <= i_cfg_data;
                REG_SPEED_KP:       r_speed_kp       <= i_cfg_data;
                REG_SPEED_KI:       r_speed_ki       <= i_cfg_data;
                REG_YAW_KD:         r_yaw_kd         <= i_cfg_data;
                REG_MID_ANGLE:      r_mid_angle      <= i_cfg_data[24:0];
                REG_SPEED_SETPOINT: r_speed_setpoint <= i_cfg_data[16:0];
                REG_DRIVE_LIMIT:    r_drive_limit    <= i_cfg_data[15:0];
                default:            r_drive_limit    <= r_drive_limit;
            endcase
        end
    end

    // Sequencer and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_filt_err   <= 18'sd0;
            r_integral   <= 15'sd0;
            r_last_angle <= 32'sd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_LIFT;
                    end
                end
                ST_LIFT: r_state <= ST_M1;
                ST_M1: begin
                    // A lifted robot restarts the speed loop from zero.
                    if (!on_ground) begin
                        r_filt_err <= 18'sd0;
                        r_integral <= 15'sd0;
                    end
                    r_state <= ST_M2;
                end
                ST_M2: r_state <= ST_A2;
                ST_A2: r_state <= ST_FE;
                ST_FE: begin
                    r_filt_err <= acc_q16[17:0];
                    r_state    <= ST_INT;
                end
                ST_INT: begin
                    r_integral <= int_next;
                    r_state    <= ST_M3;
                end
                ST_M3:   r_state <= ST_M4;
                ST_M4:   r_state <= ST_A4;
                ST_A4:   r_state <= ST_VEL;
                ST_VEL:  r_state <= ST_DIFF;
                ST_DIFF: r_state <= ST_M5;
                ST_M5:   r_state <= ST_M6;
                ST_M6:   r_state <= ST_A6;
                ST_A6:   r_state <= ST_VERT;
                ST_VERT: begin
                    // The PD output always fits in 32 bits.
                    r_last_angle <= acc_q32[31:0];
                    r_state      <= ST_L7;
                end
                ST_L7:   r_state <= ST_TURN;
                ST_TURN: r_state <= ST_DRV;
                ST_DRV: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Frame datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left_count  <= i_left_count;
            r_right_count <= i_right_count;
            r_roll_q      <= roll_q_in;
            r_rrate_q     <= rrate_q_in;
            r_yrate_q     <= yrate_q_in;
        end
        if (r_state == ST_LIFT) begin
            r_err <= err_next;
        end
        if (r_state == ST_VEL) begin
            r_vel <= sat32(acc_q16);
        end
        if (r_state == ST_DIFF) begin
            r_diff <= sat32({{15{diff_wide[49]}}, diff_wide});
        end
        if (r_state == ST_TURN) begin
            // The yaw term stays below 2^26 in magnitude.
            r_turn <= acc_q32[26:0];
        end
        if (out_load) begin
            r_left_drive    <= on_ground ? m1_clamped : 17'sd0;
            r_right_drive   <= on_ground ? m2_clamped : 17'sd0;
            r_drive_enabled <= on_ground;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_left_drive    = r_left_drive;
    assign o_right_drive   = r_right_drive;
    assign o_drive_enabled = r_drive_enabled;

endmodule
`default_nettype wire
